>>> hdl/first_fit_disk_packer_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit disk packer checker
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_DISK_PACKER_TOP_ASSERT_SVH
`define FIRST_FIT_DISK_PACKER_TOP_ASSERT_SVH

// same-cycle implication
`define FFDP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FFDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ffdp_pkg.sv
// ---------------------------------------------------------------------------
// ffdp_pkg
// Types and constants shared by the first-fit disk packer modules.
// ---------------------------------------------------------------------------
package ffdp_pkg;

  localparam int SIZE_W    = 40;
  localparam int RESERVE_W = 21;
  localparam int USED_W    = 42;
  localparam int OUT_IDX_W = 5;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 64;

  localparam logic [SIZE_W-1:0]    CAPACITY_RESET = 40'd600000000;
  localparam logic [RESERVE_W-1:0] RESERVE_RESET  = 21'd20480;

  // rounding to 1 KiB on a size that has grown by one bit
  localparam logic [SIZE_W:0] ROUND_ADD  = 41'd1023;
  localparam logic [SIZE_W:0] ROUND_MASK = ~41'd1023;

  localparam logic [USED_W-1:0] USED_MAX = '1;

  typedef enum logic [0:0] {
    REG_CAPACITY = 1'b0,
    REG_RESERVE  = 1'b1
  } reg_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [SIZE_W-1:0] file_size;
    logic              top_level;
  } job_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] disk_number;
    logic                 placed;
    logic [OUT_IDX_W-1:0] highest_disk;
  } result_t;

  typedef struct packed {
    logic [SIZE_W-1:0]    capacity;
    logic [RESERVE_W-1:0] reserve;
  } cfg_t;

endpackage

>>> hdl/first_fit_disk_packer_top.sv
// ---------------------------------------------------------------------------
// first_fit_disk_packer_top
// First-fit disk assignment with per-disk used amounts held in a RAM.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  job      | start, busy           | job.file_size, job.top_level
//  result   | done (1-cycle strobe) | disk_number, placed, highest_disk
//  config   | APB psel/penable      | paddr, pwdata, prdata (0: cap, 8: rsv)
//
// One transaction at a time. The used-amount RAM is read one disk per cycle,
// compare in the cycle after the read; a hit or the last disk ends the scan,
// then a write-back state (ST_COMMIT). A top-level file ends the scan at disk 0.
// Synchronous reset clears the per-disk valid bits at once; no clear pass.
// The result strobe cannot be stalled and coincides with busy going low.
// ---------------------------------------------------------------------------
module first_fit_disk_packer_top
  import ffdp_pkg::*;
#(
  parameter int NUM_DISKS = 20
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  job_t               job,
  output logic               done,
  output result_t            result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W = $clog2(NUM_DISKS + 1);
  localparam int AW    = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
  localparam logic [IDX_W-1:0] NONE_IDX = IDX_W'(NUM_DISKS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_DISKS - 1);

  cfg_t cfg;

  state_t state, state_next;

  logic [IDX_W-1:0]    ridx;
  logic [IDX_W-1:0]    cidx;
  logic                cvalid;
  logic [SIZE_W-1:0]   size_q;
  logic                top_q;
  logic [SIZE_W:0]     size_res;
  logic [SIZE_W:0]     rounded;
  logic [IDX_W-1:0]    chosen;
  logic                placed_q;
  logic [USED_W-1:0]   new_used;
  logic [IDX_W-1:0]    highest_seen;
  logic [IDX_W-1:0]    highest_next;
  logic [NUM_DISKS-1:0] valid;

  logic                accept;
  logic                mem_re;
  logic                mem_we;
  logic [USED_W-1:0]   rdata;
  logic [USED_W-1:0]   used_eff;
  logic [SIZE_W:0]     test_size;
  logic [USED_W:0]     fit_sum;
  logic [USED_W:0]     charge_sum;
  logic [USED_W-1:0]   charge_sat;
  logic                fits;
  logic                last;
  logic                scan_end;

  ffdp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ffdp_ram #(
    .WIDTH (USED_W),
    .DEPTH (NUM_DISKS)
  ) u_used_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (chosen[AW-1:0]),
    .wdata (new_used),
    .re    (mem_re),
    .raddr (ridx[AW-1:0]),
    .rdata (rdata)
  );

  assign accept = start && !busy;

  // never-written disks read as empty
  assign used_eff  = valid[cidx[AW-1:0]] ? rdata : '0;
  assign test_size = (cidx == '0) ? size_res : {1'b0, size_q};
  assign fit_sum   = {1'b0, used_eff} + {{(USED_W-SIZE_W){1'b0}}, test_size};
  assign last      = (cidx == LAST_IDX);
  // top-level files take disk 0 without a fit test
  assign fits      = top_q ? (cidx == '0)
                           : (fit_sum < {{(USED_W+1-SIZE_W){1'b0}}, cfg.capacity});
  assign scan_end  = cvalid && (fits || last);

  assign charge_sum = {1'b0, used_eff} + {{(USED_W-SIZE_W){1'b0}}, rounded};
  assign charge_sat = charge_sum[USED_W] ? USED_MAX : charge_sum[USED_W-1:0];

  assign highest_next = (!top_q && (chosen > highest_seen)) ? chosen : highest_seen;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (scan_end) state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy   = 1'b1;
    mem_re = 1'b0;
    mem_we = 1'b0;
    case (state)
      ST_IDLE:   busy = 1'b0;
      ST_SCAN:   mem_re = (ridx < NONE_IDX);
      ST_COMMIT: mem_we = placed_q;
      default:   busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      cvalid       <= 1'b0;
      valid        <= '0;
      highest_seen <= '0;
    end else begin
      state <= state_next;
      done  <= (state == ST_COMMIT);
      case (state)
        ST_IDLE: begin
          cvalid <= 1'b0;
        end
        ST_SCAN: begin
          cvalid <= 1'b1;
        end
        ST_COMMIT: begin
          cvalid       <= 1'b0;
          highest_seen <= highest_next;
          if (placed_q) begin
            valid[chosen[AW-1:0]] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      size_q   <= job.file_size;
      top_q    <= job.top_level;
      size_res <= {1'b0, job.file_size} + {{(SIZE_W+1-RESERVE_W){1'b0}}, cfg.reserve};
      rounded  <= ({1'b0, job.file_size} + ROUND_ADD) & ROUND_MASK;
      ridx     <= '0;
    end else if (state == ST_SCAN) begin
      if (ridx < NONE_IDX) begin
        ridx <= ridx + 1'b1;
      end
      cidx <= ridx;
      if (scan_end) begin
        chosen   <= fits ? cidx : NONE_IDX;
        placed_q <= fits;
        new_used <= charge_sat;
      end
    end
    if (state == ST_COMMIT) begin
      result.disk_number  <= OUT_IDX_W'(chosen);
      result.placed       <= placed_q;
      result.highest_disk <= OUT_IDX_W'(highest_next);
    end
  end

endmodule

>>> hdl/ffdp_ram.sv
// ---------------------------------------------------------------------------
// ffdp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffdp_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 20,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/ffdp_regs.sv
// ---------------------------------------------------------------------------
// ffdp_regs
// APB register file: disk capacity and catalog reserve.
// ---------------------------------------------------------------------------
module ffdp_regs
  import ffdp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  reg_sel_t sel;
  logic     wr;

  // registers sit on 8-byte boundaries; low address bits are ignored
  assign sel    = reg_sel_t'(paddr[3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity <= CAPACITY_RESET;
      cfg.reserve  <= RESERVE_RESET;
    end else if (wr) begin
      case (sel)
        REG_CAPACITY: cfg.capacity <= pwdata[SIZE_W-1:0];
        REG_RESERVE:  cfg.reserve  <= pwdata[RESERVE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_CAPACITY: prdata = {{(PDATA_W-SIZE_W){1'b0}}, cfg.capacity};
      REG_RESERVE:  prdata = {{(PDATA_W-RESERVE_W){1'b0}}, cfg.reserve};
      default:      prdata = '0;
    endcase
  end

endmodule

>>> hdl/ffdp_checker.sv
// ---------------------------------------------------------------------------
// ffdp_checker
// Port-level checks on the job and result handshakes of the disk packer.
// ---------------------------------------------------------------------------
`include "first_fit_disk_packer_top_assert.svh"

module ffdp_checker
  import ffdp_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  `FFDP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted job did not raise busy")
  `FFDP_ASSERT_NOW(a_done_idle, done, !busy, "result strobed while busy")
  `FFDP_ASSERT_NOW(a_fall_done, $fell(busy), done, "busy dropped without a result")
  `FFDP_ASSERT_NOW(a_unplaced_high, done && !result.placed, result.highest_disk == result.disk_number, "unplaced file did not raise highest disk")

endmodule

bind first_fit_disk_packer_top ffdp_checker u_checker (.*);
